/* src/least_loaded_unit_allocator_defines.svh */
// Assertion macros for the least-loaded unit allocator checker.
`ifndef LEAST_LOADED_UNIT_ALLOCATOR_DEFINES_SVH
`define LEAST_LOADED_UNIT_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define LLUA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define LLUA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/llua_pkg.sv */
// Shared types and codes of the least-loaded unit allocator.
`default_nettype none

package llua_pkg;

  localparam int UNIT_W   = 6;
  localparam int LOADED_W = 7;
  localparam int BUSY_W   = 9;
  localparam int DEV_W    = 4;

  localparam logic [BUSY_W-1:0] BUSY_MAX = 9'd511;

  localparam logic [2:0] OP_LOAD      = 3'd0;
  localparam logic [2:0] OP_GRAB_SEL  = 3'd1;
  localparam logic [2:0] OP_GRAB_EXCL = 3'd2;
  localparam logic [2:0] OP_PUT       = 3'd3;
  localparam logic [2:0] OP_PUT_BL    = 3'd4;
  localparam logic [2:0] OP_CLEAR     = 3'd5;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NONE    = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_IGNORED = 2'd3;

  // Request context; all but max_sharers held steady for the whole scan.
  typedef struct packed {
    logic [2:0]          op;
    logic [3:0]          node;
    logic [4:0]          dev;
    logic [6:0]          func;
    logic [6:0]          inst;
    logic [15:0]         excl;
    logic [3:0]          max_sharers;
    logic [UNIT_W-1:0]   target;
    logic [LOADED_W-1:0] loaded;
  } cell_ctl_t;

  // State updates issued when a request completes.
  typedef struct packed {
    logic              load;
    logic [2:0]        ld_node;
    logic [DEV_W-1:0]  ld_dev;
    logic [5:0]        ld_func;
    logic [5:0]        ld_inst;
    logic              ld_blk;
    logic              inc;
    logic              dec;
    logic              blacklist;
    logic [UNIT_W-1:0] unit;
    logic              clear;
    logic              busy_we;
    logic [DEV_W-1:0]  busy_idx;
    logic [BUSY_W-1:0] busy_val;
  } cell_upd_t;

  // Scan token passed from cell to cell.
  typedef struct packed {
    logic              valid;
    logic              have;
    logic [UNIT_W-1:0] unit;
    logic [BUSY_W-1:0] cnt;
    logic [DEV_W-1:0]  dev;
  } token_t;

endpackage

`default_nettype wire

/* src/llua_channels.sv */
// Request and response channel interfaces of the allocator.
`default_nettype none

interface llua_req_if;
  logic              valid;
  logic              ready;
  logic [2:0]        op;
  logic [4:0]        unit_index;
  logic signed [3:0] numa_node;
  logic signed [4:0] device_number;
  logic signed [6:0] function_number;
  logic signed [6:0] instance_number;
  logic              started_ok;
  logic [15:0]       exclude_devices;

  modport source (output valid, op, unit_index, numa_node, device_number,
                  function_number, instance_number, started_ok, exclude_devices,
                  input ready);
  modport sink (input valid, op, unit_index, numa_node, device_number,
                function_number, instance_number, started_ok, exclude_devices,
                output ready);
endinterface

interface llua_rsp_if;
  logic       valid;
  logic       ready;
  logic       found;
  logic [4:0] chosen_unit;
  logic [3:0] chosen_device;
  logic [1:0] status;

  modport source (output valid, found, chosen_unit, chosen_device, status,
                  input ready);
  modport sink (input valid, found, chosen_unit, chosen_device, status,
                output ready);
endinterface

`default_nettype wire

/* src/llua_cell.sv */
// One unit entry of the allocator chain with its stage of the scan token.
`default_nettype none

module llua_cell import llua_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic      clk,
  input  logic      rst,
  input  cell_ctl_t ctl,
  input  cell_upd_t upd,
  input  token_t    tok_in,
  output token_t    tok_out
);

  localparam logic [UNIT_W-1:0]   MY_IDX = UNIT_W'(IDX);
  localparam logic [LOADED_W-1:0] MY_POS = LOADED_W'(IDX);

  logic [2:0]        node;
  logic [DEV_W-1:0]  dev;
  logic [5:0]        func;
  logic [5:0]        inst;
  logic [DEV_W-1:0]  bidx;
  logic [BUSY_W-1:0] busy_copy;
  logic [3:0]        refs;
  logic              blk;

  logic              t_valid;
  logic              t_have;
  logic [UNIT_W-1:0] t_unit;
  logic [BUSY_W-1:0] t_cnt;
  logic [DEV_W-1:0]  t_dev;

  logic loaded, usable, sel_ok, excl_ok, cand;
  logic take_grab, take_put, take;
  logic load_hit, upd_hit;

  assign loaded   = MY_POS < ctl.loaded;
  assign load_hit = upd.load && (MY_POS == ctl.loaded);
  assign upd_hit  = upd.unit == MY_IDX;

  assign usable  = loaded && !blk && (refs < ctl.max_sharers);
  // a negative filter id is a wildcard
  assign sel_ok  = (ctl.node[3] || (ctl.node[2:0] == node)) &&
                   (ctl.dev[4]  || (ctl.dev[3:0]  == dev))  &&
                   (ctl.func[6] || (ctl.func[5:0] == func)) &&
                   (ctl.inst[6] || (ctl.inst[5:0] == inst));
  assign excl_ok = !ctl.excl[dev];
  assign cand    = usable && ((ctl.op == OP_GRAB_SEL) ? sel_ok : excl_ok);

  assign take_grab = ((ctl.op == OP_GRAB_SEL) || (ctl.op == OP_GRAB_EXCL)) && cand &&
                     (!tok_in.have || (busy_copy < tok_in.cnt));
  assign take_put  = ((ctl.op == OP_PUT) || (ctl.op == OP_PUT_BL)) &&
                     (ctl.target == MY_IDX) && loaded && (refs != 4'd0);
  assign take      = tok_in.valid && (take_grab || take_put);

  always_ff @(posedge clk) begin
    if (rst) begin
      refs <= 4'd0;
      blk  <= 1'b0;
    end else begin
      priority if (upd.clear) begin
        refs <= 4'd0;
        blk  <= 1'b0;
      end else if (load_hit) begin
        refs <= 4'd0;
        blk  <= upd.ld_blk;
      end else if (upd.inc && upd_hit) begin
        refs <= refs + 4'd1;
      end else if (upd.dec && upd_hit) begin
        refs <= refs - 4'd1;
        if (upd.blacklist) begin
          blk <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_hit) begin
      node <= upd.ld_node;
      dev  <= upd.ld_dev;
      func <= upd.ld_func;
      inst <= upd.ld_inst;
      bidx <= upd.busy_idx;
    end
    if (upd.busy_we && (load_hit || (bidx == upd.busy_idx))) begin
      busy_copy <= upd.busy_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t_valid <= 1'b0;
    end else begin
      t_valid <= tok_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      t_have <= 1'b1;
      t_unit <= MY_IDX;
      t_cnt  <= busy_copy;
      t_dev  <= dev;
    end else begin
      t_have <= tok_in.have;
      t_unit <= tok_in.unit;
      t_cnt  <= tok_in.cnt;
      t_dev  <= tok_in.dev;
    end
  end

  assign tok_out = '{valid: t_valid, have: t_have, unit: t_unit, cnt: t_cnt, dev: t_dev};

endmodule

`default_nettype wire

/* src/least_loaded_unit_allocator.sv */
// Least-loaded unit allocator: unit table as a chain of cells, one request at a time.
//
// Holds up to NUM_UNITS accelerator units and a busy count per device. A grab or a
// put back sends a token down the chain of unit cells, one cell per cycle, and its
// result is taken from the token that leaves the last cell; load, clear and unused
// ops skip the chain and go to the finish state. A new request is taken while the
// last result still waits on rsp; the next result waits for that one to be taken.
// max_sharers is written through cfg_we/cfg_data and resets to 1. No clearing pass
// follows reset.
`default_nettype none

module least_loaded_unit_allocator import llua_pkg::*; #(
  parameter int NUM_UNITS   = 32,
  parameter int NUM_DEVICES = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [3:0]        cfg_data,
  llua_req_if.sink          req,
  llua_rsp_if.source        rsp
);

  localparam int NBUSY = (NUM_DEVICES < 16) ? NUM_DEVICES : 16;
  localparam int BW    = (NBUSY > 1) ? $clog2(NBUSY) : 1;
  localparam int LW    = $clog2(NUM_UNITS + 1);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  state_t state;

  logic [2:0]  req_op;
  logic [4:0]  req_idx;
  logic [3:0]  req_node;
  logic [4:0]  req_dev;
  logic [6:0]  req_func;
  logic [6:0]  req_inst;
  logic        req_ok;
  logic [15:0] req_excl;

  logic [3:0]        max_sharers;
  logic [LW-1:0]     units_loaded;
  logic [BUSY_W-1:0] busy [NBUSY];
  logic              launch;
  token_t            res_tok;

  logic       out_valid;
  logic       out_found;
  logic [4:0] out_unit;
  logic [3:0] out_dev;
  logic [1:0] out_status;

  logic [DEV_W-1:0] dev_map [16];

  token_t    tok [NUM_UNITS+1];
  cell_ctl_t ctl;
  cell_upd_t upd;

  logic is_grab, is_put, is_load, is_clear, full, commit, accept;
  logic [DEV_W-1:0]  bsel;
  logic [BUSY_W-1:0] bcur, bnext;
  logic              busy_we;

  logic       res_found;
  logic [4:0] res_unit;
  logic [3:0] res_dev;
  logic [1:0] res_status;

  // device id to busy counter
  for (genvar d = 0; d < 16; d++) begin : g_map
    assign dev_map[d] = DEV_W'(d % NUM_DEVICES);
  end

  assign is_grab  = (req_op == OP_GRAB_SEL) || (req_op == OP_GRAB_EXCL);
  assign is_put   = (req_op == OP_PUT) || (req_op == OP_PUT_BL);
  assign is_load  = req_op == OP_LOAD;
  assign is_clear = req_op == OP_CLEAR;
  assign full     = units_loaded >= LW'(NUM_UNITS);

  assign accept  = req.valid && req.ready;
  assign commit  = (state == S_FINISH) && (!out_valid || rsp.ready);
  assign req.ready = state == S_IDLE;

  assign bsel = is_load ? dev_map[req_dev[3:0]] : dev_map[res_tok.dev];
  assign bcur = busy[bsel[BW-1:0]];

  always_comb begin
    bnext = bcur;
    if (is_grab && res_tok.have && (bcur < BUSY_MAX)) begin
      bnext = bcur + 9'd1;
    end else if (is_put && res_tok.have && (bcur != 9'd0)) begin
      bnext = bcur - 9'd1;
    end
  end

  assign busy_we = commit && ((is_load && !full) || ((is_grab || is_put) && res_tok.have));

  always_comb begin
    res_found  = 1'b0;
    res_unit   = 5'd0;
    res_dev    = 4'd0;
    res_status = ST_OK;
    unique case (req_op)
      OP_LOAD: begin
        if (full) begin
          res_status = ST_FULL;
        end else begin
          res_unit = 5'(units_loaded);
          res_dev  = req_dev[3:0];
        end
      end
      OP_GRAB_SEL, OP_GRAB_EXCL: begin
        if (res_tok.have) begin
          res_found = 1'b1;
          res_unit  = 5'(res_tok.unit);
          res_dev   = res_tok.dev;
        end else begin
          res_status = ST_NONE;
        end
      end
      OP_PUT, OP_PUT_BL: begin
        if (res_tok.have) begin
          res_unit = 5'(res_tok.unit);
          res_dev  = res_tok.dev;
        end else begin
          res_status = ST_IGNORED;
        end
      end
      default: begin
      end
    endcase
  end

  assign ctl = '{op: req_op, node: req_node, dev: req_dev, func: req_func,
                 inst: req_inst, excl: req_excl, max_sharers: max_sharers,
                 target: UNIT_W'(req_idx), loaded: LOADED_W'(units_loaded)};

  assign upd = '{load: commit && is_load && !full,
                 ld_node: req_node[2:0], ld_dev: req_dev[3:0],
                 ld_func: req_func[5:0], ld_inst: req_inst[5:0], ld_blk: !req_ok,
                 inc: commit && is_grab && res_tok.have,
                 dec: commit && is_put && res_tok.have,
                 blacklist: req_op == OP_PUT_BL, unit: res_tok.unit,
                 clear: commit && is_clear,
                 busy_we: busy_we, busy_idx: bsel, busy_val: bnext};

  assign tok[0] = '{valid: launch, have: 1'b0, unit: '0, cnt: '0, dev: '0};

  for (genvar i = 0; i < NUM_UNITS; i++) begin : g_cell
    llua_cell #(.IDX(i)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl     (ctl),
      .upd     (upd),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      launch <= 1'b0;
    end else begin
      launch <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if ((req.op == OP_GRAB_SEL) || (req.op == OP_GRAB_EXCL) ||
                (req.op == OP_PUT) || (req.op == OP_PUT_BL)) begin
              state  <= S_SCAN;
              launch <= 1'b1;
            end else begin
              state <= S_FINISH;
            end
          end
        end
        S_SCAN: begin
          if (tok[NUM_UNITS].valid) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (commit) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_op   <= req.op;
      req_idx  <= req.unit_index;
      req_node <= req.numa_node;
      req_dev  <= req.device_number;
      req_func <= req.function_number;
      req_inst <= req.instance_number;
      req_ok   <= req.started_ok;
      req_excl <= req.exclude_devices;
    end
    if ((state == S_SCAN) && tok[NUM_UNITS].valid) begin
      res_tok <= tok[NUM_UNITS];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_sharers  <= 4'd1;
      units_loaded <= '0;
      for (int b = 0; b < NBUSY; b++) begin
        busy[b] <= '0;
      end
    end else begin
      if (cfg_we) begin
        max_sharers <= cfg_data;
      end
      if (upd.clear) begin
        units_loaded <= '0;
        for (int b = 0; b < NBUSY; b++) begin
          busy[b] <= '0;
        end
      end else begin
        if (upd.load) begin
          units_loaded <= units_loaded + LW'(1);
        end
        if (busy_we) begin
          busy[bsel[BW-1:0]] <= bnext;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_found  <= res_found;
      out_unit   <= res_unit;
      out_dev    <= res_dev;
      out_status <= res_status;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.found         = out_found;
  assign rsp.chosen_unit   = out_unit;
  assign rsp.chosen_device = out_dev;
  assign rsp.status        = out_status;

endmodule

`default_nettype wire

/* src/llua_checker.sv */
// Port-level assertion checker for the allocator and its bind.
`default_nettype none

`include "least_loaded_unit_allocator_defines.svh"

module llua_checker import llua_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       req_valid,
  input logic       req_ready,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic       rsp_found,
  input logic [4:0] rsp_unit,
  input logic [3:0] rsp_device,
  input logic [1:0] rsp_status
);

  `LLUA_ASSERT_NXT(a_one_request, req_valid && req_ready, !req_ready, "request taken while busy")
  `LLUA_ASSERT_IMP(a_found_ok, rsp_valid && rsp_found, rsp_status == ST_OK, "found without ok")
  `LLUA_ASSERT_IMP(a_fail_zero, rsp_valid && (rsp_status != ST_OK), !rsp_found && (rsp_unit == 5'd0) && (rsp_device == 4'd0), "failed response not cleared")
  `LLUA_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "response dropped while stalled")

endmodule

bind least_loaded_unit_allocator llua_checker u_llua_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .rsp_found  (rsp.found),
  .rsp_unit   (rsp.chosen_unit),
  .rsp_device (rsp.chosen_device),
  .rsp_status (rsp.status)
);

`default_nettype wire
